FILE: rtl/aesd_pkg.sv
// Package: AES-128 decrypt constants, tables and byte-level functions.
`timescale 1ns / 1ps
package aesd_pkg;

  localparam int unsigned KeyWords   = 22;
  localparam int unsigned Rounds     = 10;
  localparam int unsigned AddrWidth  = 4;

  localparam logic [AddrWidth-1:0] RegKeyHigh = 4'h0;
  localparam logic [AddrWidth-1:0] RegKeyLow  = 4'h8;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // InvMixColumns on one column, a[0] is row 0
  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] o [4];
    for (int r = 0; r < 4; r++) begin
      a[r]  = col[31-8*r -: 8];
      x2[r] = xtime(a[r]);
      x4[r] = xtime(x2[r]);
      x8[r] = xtime(x4[r]);
      m9[r] = x8[r] ^ a[r];
      mb[r] = x8[r] ^ x2[r] ^ a[r];
      md[r] = x8[r] ^ x4[r] ^ a[r];
      me[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    for (int r = 0; r < 4; r++)
      o[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
    inv_mix_col = {o[0], o[1], o[2], o[3]};
  endfunction

endpackage

FILE: rtl/aes128_block_decrypt.sv
// Top level: AES-128 inverse cipher with key schedule store and shared round unit.
//
//  channel | dir | transaction
//  s_axis  | in  | cipher block, tdata = {cipher_low, cipher_high}
//  m_axis  | out | plain block,  tdata = {plain_low, plain_high}
//  apb     | in  | key_high at 0x0, key_low at 0x8
//
// Eleven round keys (10 down to 0) each take two store reads, one per 64-bit
// half. Key 10 is XORed in directly; keys 9 to 0 go through the round unit. The
// output register is then loaded from S_OUT. After reset or a key write, the
// first block first runs the key expansion, which writes all 22 64-bit store
// words. Input is ready only while idle.
// A finished block holds in the output stage while a result waits on m_axis.
`timescale 1ns / 1ps
module aes128_block_decrypt
  import aesd_pkg::*;
#(
  parameter int unsigned NumWords = KeyWords
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [127:0]         s_axis_tdata,   // cipher_high[63:0], cipher_low[127:64]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [127:0]         m_axis_tdata,   // plain_high[63:0], plain_low[127:64]
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  localparam int unsigned WA = $clog2(NumWords);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXPAND = 6'b000010,
    S_KFETCH = 6'b000100,
    S_KADD   = 6'b001000,
    S_ROUND  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t         state;
  logic [63:0]    key_high;
  logic [63:0]    key_low;
  logic           keys_ready;
  logic [127:0]   sched;
  logic [7:0]     rcon;
  logic [3:0]     rnd;
  logic           half;
  logic [127:0]   blk;
  logic [127:0]   rk;
  logic [63:0]    rk_hi;
  logic [127:0]   round_out;
  logic [127:0]   sched_next;
  logic           we;
  logic [WA-1:0]  waddr;
  logic [63:0]    wdata;
  logic [WA-1:0]  raddr;
  logic [63:0]    rdata;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == RegKeyHigh) ? key_high : (paddr == RegKeyLow) ? key_low : 64'd0;

  assign s_axis_tready = (state == S_IDLE);

  // next round key of the schedule
  always_comb begin
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = sched[127-32*i -: 32];
    t = {sbox(w[3][23:16]), sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])}
        ^ {rcon, 24'd0};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    sched_next = {w[0], w[1], w[2], w[3]};
  end

  // write both halves of a round key: high half while half=0, low half next; reads use the same address
  always_comb begin
    we    = 1'b0;
    waddr = {rnd[WA-2:0], half};
    wdata = half ? sched[63:0] : sched[127:64];
    raddr = {rnd[WA-2:0], half};
    case (state)
      S_EXPAND: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  aesd_ram #(.Width(64), .Depth(NumWords)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rk = {rk_hi, rdata};

  aesd_round u_round (
    .state_in(blk), .round_key(rk), .mix(rnd != 4'd0), .state_out(round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      key_high      <= 64'd0;
      key_low       <= 64'd0;
      keys_ready    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      rnd           <= 4'd0;
      half          <= 1'b0;
    end else begin
      if (cfg_wr && paddr == RegKeyHigh) begin
        key_high   <= pwdata;
        keys_ready <= 1'b0;
      end else if (cfg_wr && paddr == RegKeyLow) begin
        key_low    <= pwdata;
        keys_ready <= 1'b0;
      end
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tdata  <= {blk[63:0], blk[127:64]};
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            blk <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            if (keys_ready) begin
              rnd   <= 4'(Rounds);
              half  <= 1'b0;
              state <= S_KFETCH;
            end else begin
              sched <= {key_high, key_low};
              rcon  <= 8'h01;
              rnd   <= 4'd0;
              half  <= 1'b0;
              state <= S_EXPAND;
            end
          end
        end
        S_EXPAND: begin
          half <= ~half;
          if (half) begin
            if (rnd == 4'(Rounds)) begin
              keys_ready <= 1'b1;
              rnd        <= 4'(Rounds);
              half       <= 1'b0;
              state      <= S_KFETCH;
            end else begin
              sched <= sched_next;
              rcon  <= xtime(rcon);
              rnd   <= rnd + 4'd1;
            end
          end
        end
        S_KFETCH: begin
          // high half read issued while half=0; with half=1 it is latched and the low half read issued
          half <= ~half;
          if (half) state <= S_KADD;
        end
        S_KADD: begin
          // rdata holds low half, rk_hi holds high half
          if (rnd == 4'(Rounds)) blk <= blk ^ rk;
          else blk <= round_out;
          if (rnd == 4'd0) begin
            state <= S_OUT;
          end else begin
            rnd   <= rnd - 4'd1;
            half  <= 1'b0;
            state <= S_KFETCH;
          end
        end
        S_OUT: begin
          // hold the finished block until the output register frees up
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // rk_hi captures the high half from rdata while half=1 in S_KFETCH
  always_ff @(posedge clk) begin
    if (state == S_KFETCH && half) rk_hi <= rdata;
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a second block while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> m_axis_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_EXPAND))
    else $error("store written outside expansion");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_KFETCH || state == S_KADD) |-> keys_ready)
    else $error("round keys used before expansion");
endmodule

FILE: rtl/aesd_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module aesd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/aesd_round.sv
// Shared inverse round unit: InvShiftRows, InvSubBytes, AddRoundKey, optional InvMixColumns.
`timescale 1ns / 1ps
module aesd_round
  import aesd_pkg::*;
(
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         mix,
  output logic [127:0] state_out
);
  logic [7:0]   b [16];
  logic [7:0]   t [16];
  logic [127:0] added;

  always_comb begin
    for (int i = 0; i < 16; i++) b[i] = state_in[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*((c+r)%4)+r] = inv_sbox(b[4*c+r]);
    for (int i = 0; i < 16; i++) added[127-8*i -: 8] = t[i] ^ round_key[127-8*i -: 8];
    if (mix) begin
      for (int c = 0; c < 4; c++) state_out[127-32*c -: 32] = inv_mix_col(added[127-32*c -: 32]);
    end else begin
      state_out = added;
    end
  end
endmodule
